@@ rtl/core/packet_lag_delay_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the packet lag delay queue datapath.
// ----------------------------------------------------------------------------
`ifndef PACKET_LAG_DELAY_QUEUE_CORE_MACROS_SVH
`define PACKET_LAG_DELAY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pldq_pkg.sv @@
// ----------------------------------------------------------------------------
// pldq_pkg
// Types and constants of the packet lag delay queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pldq_pkg;

    localparam logic [13:0] LAG_MAX_MS   = 14'd15000;
    localparam logic [13:0] LAG_RESET_MS = 14'd50;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [1:0] {
        CAUSE_PASS    = 2'd0,
        CAUSE_RELEASE = 2'd1,
        CAUSE_FLUSH   = 2'd2
    } t_cause;

    typedef enum logic [1:0] {
        CFG_LAG_MS       = 2'd0,
        CFG_LAG_INBOUND  = 2'd1,
        CFG_LAG_OUTBOUND = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH,
        ST_PASS,
        ST_LAST
    } t_state;

    typedef struct packed {
        logic [15:0] handle;
        logic        outbound;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [15:0] handle;
        logic        outbound;
        t_cause      cause;
        logic        last;
    } t_result;

    typedef struct packed {
        logic   accept;
        logic   pop;
        t_cause pop_cause;
        logic   emit_pass;
        logic   finish;
        logic   flush_load;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic held_zero;
        logic full;
        logic pass;
        logic can_emit;
        logic out_free;
        logic pend_valid;
        logic flush_done;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/pldq_item_if.sv @@
// ----------------------------------------------------------------------------
// pldq_item_if
// Input channel: packet arrivals and time ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pldq_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] packet_handle;
    logic        is_outbound;
    logic [31:0] now_ms;

    modport source (output valid, kind, packet_handle, is_outbound, now_ms, input ready);
    modport sink (input valid, kind, packet_handle, is_outbound, now_ms, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pldq_result_if.sv @@
// ----------------------------------------------------------------------------
// pldq_result_if
// Output channel: packets sent on, with the reason and an end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pldq_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_handle;
    logic        out_outbound;
    logic [1:0]  cause;
    logic        last;

    modport source (output valid, out_handle, out_outbound, cause, last, input ready);
    modport sink (input valid, out_handle, out_outbound, cause, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pldq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pldq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pldq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [13:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pldq_dp.sv @@
// ----------------------------------------------------------------------------
// pldq_dp
// Datapath: queue memory, pointers, lag registers, due compare and the
// result staging and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_lag_delay_queue_core_macros.svh"

module pldq_dp #(
    parameter int QUEUE_DEPTH = 32,
    parameter int FLUSH_COUNT = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pldq_pkg::t_cmd       i_cmd,
    output pldq_pkg::t_stat      o_stat,
    input  wire                  i_kind,
    input  wire  [15:0]          i_packet_handle,
    input  wire                  i_is_outbound,
    input  wire  [31:0]          i_now_ms,
    input  wire                  i_cfg_valid,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [13:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [15:0]          o_out_handle,
    output logic                 o_out_outbound,
    output logic [1:0]           o_out_cause,
    output logic                 o_out_last
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int HW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = $clog2(FLUSH_COUNT + 1);

    pldq_pkg::t_entry  r_mem [QUEUE_DEPTH];
    pldq_pkg::t_entry  r_rd_data;

    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [HW-1:0]     r_held, n_held;
    logic [FW-1:0]     r_flush_cnt, n_flush_cnt;
    logic [13:0]       r_lag_ms;
    logic              r_lag_in;
    logic              r_lag_out;

    logic              r_kind;
    logic [15:0]       r_handle;
    logic              r_dir;
    logic [31:0]       r_now;
    logic              r_pass;

    pldq_pkg::t_result r_pend, r_out;
    logic              r_pend_v, r_out_v;

    logic              enabled, enq, produce, load_out, out_free;
    logic [PW-1:0]     rd_next, rd_addr;
    logic [31:0]       due_ms;
    pldq_pkg::t_result prod, out_word;

    assign enabled = i_is_outbound ? r_lag_out : r_lag_in;
    assign enq     = i_cmd.accept && (i_kind == pldq_pkg::KIND_PACKET) && enabled
                     && (r_held != HW'(QUEUE_DEPTH));

    assign rd_next  = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    // While popping, fetch the next entry so the compare keeps one pop a cycle while the output is free.
    assign rd_addr  = i_cmd.pop ? rd_next : r_rd_ptr;

    // The stamp plus lag wraps modulo 2^32 before the compare.
    assign due_ms = r_rd_data.stamp + 32'(r_lag_ms);

    assign out_free = !r_out_v || i_out_ready;
    assign produce  = i_cmd.pop || i_cmd.emit_pass;
    assign load_out = r_pend_v && (produce || i_cmd.finish);

    always_comb begin
        if (i_cmd.pop) begin
            prod = '{handle: r_rd_data.handle, outbound: r_rd_data.outbound,
                     cause: i_cmd.pop_cause, last: 1'b0};
        end else begin
            prod = '{handle: r_handle, outbound: r_dir,
                     cause: pldq_pkg::CAUSE_PASS, last: 1'b0};
        end
        out_word      = r_pend;
        out_word.last = i_cmd.finish;
    end

    always_comb begin
        n_rd_ptr    = i_cmd.pop ? rd_next : r_rd_ptr;
        n_held      = r_held;
        n_flush_cnt = r_flush_cnt;
        if (enq) begin
            n_held = r_held + 1'b1;
        end else if (i_cmd.pop) begin
            n_held = r_held - 1'b1;
        end
        if (i_cmd.flush_load) begin
            n_flush_cnt = FW'(FLUSH_COUNT);
        end else if (i_cmd.pop && i_cmd.pop_cause == pldq_pkg::CAUSE_FLUSH) begin
            n_flush_cnt = r_flush_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_held      <= '0;
            r_flush_cnt <= '0;
            r_lag_ms    <= pldq_pkg::LAG_RESET_MS;
            r_lag_in    <= 1'b1;
            r_lag_out   <= 1'b1;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_rd_ptr    <= n_rd_ptr;
            r_held      <= n_held;
            r_flush_cnt <= n_flush_cnt;
            if (enq) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_cmd.accept) begin
                r_pass <= (i_kind == pldq_pkg::KIND_PACKET) && !enq;
            end
            if (i_cfg_valid) begin
                unique case (pldq_pkg::t_cfg_idx'(i_cfg_index))
                    pldq_pkg::CFG_LAG_MS: begin
                        r_lag_ms <= (i_cfg_data > pldq_pkg::LAG_MAX_MS) ?
                                    pldq_pkg::LAG_MAX_MS : i_cfg_data;
                    end
                    pldq_pkg::CFG_LAG_INBOUND:  r_lag_in  <= i_cfg_data[0];
                    pldq_pkg::CFG_LAG_OUTBOUND: r_lag_out <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (produce) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_kind;
            r_handle <= i_packet_handle;
            r_dir    <= i_is_outbound;
            r_now    <= i_now_ms;
        end
        if (produce) begin
            r_pend <= prod;
        end
        if (load_out) begin
            r_out <= out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wr_ptr] <= '{handle: i_packet_handle, outbound: i_is_outbound,
                                 stamp: i_now_ms};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stat = '{
        due:        (r_now > due_ms),
        held_zero:  (r_held == '0),
        full:       (r_held == HW'(QUEUE_DEPTH)),
        pass:       r_pass && (r_kind == pldq_pkg::KIND_PACKET),
        can_emit:   !r_pend_v || out_free,
        out_free:   out_free,
        pend_valid: r_pend_v,
        flush_done: (r_flush_cnt == '0)
    };

    assign o_out_valid    = r_out_v;
    assign o_out_handle   = r_out.handle;
    assign o_out_outbound = r_out.outbound;
    assign o_out_cause    = r_out.cause;
    assign o_out_last     = r_out.last;

    `PLDQ_ASSERT_NOW(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= HW'(QUEUE_DEPTH), "held count above queue depth")
    `PLDQ_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_held != '0, "pop from an empty queue")
    `PLDQ_ASSERT_NOW(a_out_overwrite, i_clk, i_rst_n, load_out, out_free, "output register overwritten before its transaction")
    `PLDQ_ASSERT_NOW(a_ptr_match, i_clk, i_rst_n, (r_held == '0) || (r_held == HW'(QUEUE_DEPTH)), r_rd_ptr == r_wr_ptr, "pointers disagree with held count")
    `PLDQ_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, i_cmd.finish && !produce, !r_pend_v, "staged result survived end of item")

endmodule

`default_nettype wire

@@ rtl/core/pldq_ctrl.sv @@
// ----------------------------------------------------------------------------
// pldq_ctrl
// Controller: sequences intake, release scan, full-queue flush, pass-through
// and the end marker of each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pldq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  pldq_pkg::t_stat  i_stat,
    output pldq_pkg::t_cmd   o_cmd
);

    pldq_pkg::t_state r_state, n_state;
    logic             release_now;

    assign release_now = !i_stat.held_zero && i_stat.due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pldq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pldq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = pldq_pkg::ST_READ;
            end
            pldq_pkg::ST_READ: begin
                n_state = pldq_pkg::ST_CHECK;
            end
            pldq_pkg::ST_CHECK: begin
                if (!release_now) begin
                    n_state = i_stat.full ? pldq_pkg::ST_FLUSH : pldq_pkg::ST_PASS;
                end
            end
            pldq_pkg::ST_FLUSH: begin
                if (i_stat.flush_done || i_stat.held_zero) n_state = pldq_pkg::ST_PASS;
            end
            pldq_pkg::ST_PASS: begin
                if (!i_stat.pass || i_stat.can_emit) n_state = pldq_pkg::ST_LAST;
            end
            pldq_pkg::ST_LAST: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = pldq_pkg::ST_IDLE;
            end
            default: n_state = pldq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pldq_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pldq_pkg::ST_READ: ;
            pldq_pkg::ST_CHECK: begin
                if (release_now) begin
                    o_cmd.pop       = i_stat.can_emit;
                    o_cmd.pop_cause = pldq_pkg::CAUSE_RELEASE;
                end else begin
                    o_cmd.flush_load = i_stat.full;
                end
            end
            pldq_pkg::ST_FLUSH: begin
                o_cmd.pop = !i_stat.flush_done && !i_stat.held_zero && i_stat.can_emit;
                o_cmd.pop_cause = pldq_pkg::CAUSE_FLUSH;
            end
            pldq_pkg::ST_PASS: begin
                o_cmd.emit_pass = i_stat.pass && i_stat.can_emit;
            end
            pldq_pkg::ST_LAST: begin
                o_cmd.finish = i_stat.pend_valid && i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/packet_lag_delay_queue_core.sv @@
// ----------------------------------------------------------------------------
// packet_lag_delay_queue_core
// Lag emulator queue: holds packets for a set delay, releases them oldest
// first, flushes a batch when full and passes the rest straight through.
//
//  Port       Dir  Payload                                    Transaction
//  i_item     in   kind, packet_handle, is_outbound, now_ms   one arrival/tick
//  o_result   out  out_handle, out_outbound, cause, last      one sent packet
//  i_cfg      in   index, data                                one register
//
// An item passes through intake, memory read, release scan, a flush when the
// queue is full after the scan, pass-through and the end marker. The single
// registered read port of the queue memory sets the one-pop-per-cycle pace.
// Results are staged one deep so the final one can carry the end marker.
// A stalled output holds the scan in place; configuration is always ready.
// Reset empties the queue and loads lag 50 ms with both directions delayed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_lag_delay_queue_core #(
    parameter int QUEUE_DEPTH = 32,
    parameter int FLUSH_COUNT = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    pldq_item_if.sink         i_item,
    pldq_result_if.source     o_result,
    pldq_cfg_if.sink          i_cfg
);

    pldq_pkg::t_cmd  cmd;
    pldq_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    pldq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pldq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FLUSH_COUNT (FLUSH_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_item.kind),
        .i_packet_handle (i_item.packet_handle),
        .i_is_outbound   (i_item.is_outbound),
        .i_now_ms        (i_item.now_ms),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_out_handle    (o_result.out_handle),
        .o_out_outbound  (o_result.out_outbound),
        .o_out_cause     (o_result.cause),
        .o_out_last      (o_result.last)
    );

endmodule

`default_nettype wire

@@ test/packet_lag_delay_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// packet_lag_delay_queue_core_tb
// Self-checking bench for the lag emulator queue. Arrivals and ticks are
// driven through a valid/ready channel, the expected sends are computed by a
// behavioral queue in the bench, and every sent packet is compared field by
// field in order. Directed items cover the release boundary, pass-through,
// lag saturation and time wrap; random traffic runs under several register
// settings, a full-queue flush and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_lag_delay_queue_core_tb;

    localparam int HELD_MAX      = 32;
    localparam int FLUSH_BATCH   = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    typedef struct {
        logic        kind;
        logic [15:0] handle;
        logic        outbound;
        logic [31:0] now_ms;
    } t_arrival;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pldq_item_if   item_bus ();
    pldq_result_if result_bus ();
    pldq_cfg_if    cfg_bus ();

    packet_lag_delay_queue_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // Bench copy of the queue and its registers.
    pldq_pkg::t_entry held_packets[$];
    logic [13:0]      lag_setting_ms = pldq_pkg::LAG_RESET_MS;
    logic             delay_inbound  = 1'b1;
    logic             delay_outbound = 1'b1;

    pldq_pkg::t_result expected_sends[$];
    pldq_pkg::t_result leftover;
    t_arrival          pending_arrivals[$];
    t_arrival          next_arrival;

    int mismatch_count = 0;
    int source_gap     = 0;
    int source_gap_max = 5;
    int sink_wait      = 0;
    int sink_wait_max  = 5;
    int hold_left      = 0;
    int holds_asked    = 0;
    int holds_served   = 0;

    logic item_taken   = 1'b0;
    logic result_taken = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic void add_send(input logic [15:0] handle, input logic outbound,
                                     input pldq_pkg::t_cause cause);
        pldq_pkg::t_result send;
        send.handle   = handle;
        send.outbound = outbound;
        send.cause    = cause;
        send.last     = 1'b0;
        expected_sends.push_back(send);
    endfunction

    function automatic void compute_sends(input t_arrival arr);
        pldq_pkg::t_entry slot;
        logic             pass_on;
        logic [31:0]      due_ms;
        int               produced;
        int               flushed;
        pass_on  = 1'b0;
        produced = 0;
        if (arr.kind == pldq_pkg::KIND_PACKET) begin
            if ((arr.outbound ? delay_outbound : delay_inbound)
                    && held_packets.size() < HELD_MAX) begin
                slot.handle   = arr.handle;
                slot.outbound = arr.outbound;
                slot.stamp    = arr.now_ms;
                held_packets.push_back(slot);
            end else begin
                pass_on = 1'b1;
            end
        end
        // The due time wraps in 32 bits before the strict comparison.
        while (held_packets.size() > 0) begin
            due_ms = held_packets[0].stamp + {18'd0, lag_setting_ms};
            if (arr.now_ms > due_ms) begin
                slot = held_packets.pop_front();
                add_send(slot.handle, slot.outbound, pldq_pkg::CAUSE_RELEASE);
                produced++;
            end else begin
                break;
            end
        end
        if (held_packets.size() >= HELD_MAX) begin
            flushed = 0;
            while (flushed < FLUSH_BATCH && held_packets.size() > 0) begin
                slot = held_packets.pop_front();
                add_send(slot.handle, slot.outbound, pldq_pkg::CAUSE_FLUSH);
                produced++;
                flushed++;
            end
        end
        if (pass_on) begin
            add_send(arr.handle, arr.outbound, pldq_pkg::CAUSE_PASS);
            produced++;
        end
        if (produced > 0)
            expected_sends[$].last = 1'b1;
    endfunction

    function automatic void apply_register(input logic [1:0] index, input logic [13:0] data);
        case (pldq_pkg::t_cfg_idx'(index))
            pldq_pkg::CFG_LAG_MS: begin
                lag_setting_ms = (data > pldq_pkg::LAG_MAX_MS) ? pldq_pkg::LAG_MAX_MS : data;
            end
            pldq_pkg::CFG_LAG_INBOUND: begin
                delay_inbound = data[0];
            end
            pldq_pkg::CFG_LAG_OUTBOUND: begin
                delay_outbound = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_send();
        pldq_pkg::t_result want;
        if (expected_sends.size() == 0) begin
            report_mismatch($sformatf("unexpected send handle %h cause %0d",
                                      result_bus.out_handle, result_bus.cause));
        end else begin
            want = expected_sends.pop_front();
            if (result_bus.out_handle !== want.handle)
                report_mismatch($sformatf("out_handle %h, expected %h",
                                          result_bus.out_handle, want.handle));
            if (result_bus.out_outbound !== want.outbound)
                report_mismatch($sformatf("out_outbound %b, expected %b",
                                          result_bus.out_outbound, want.outbound));
            if (result_bus.cause !== want.cause)
                report_mismatch($sformatf("cause %0d, expected %0d",
                                          result_bus.cause, want.cause));
            if (result_bus.last !== want.last)
                report_mismatch($sformatf("last %b, expected %b",
                                          result_bus.last, want.last));
        end
    endtask

    // Monitor: everything is sampled at the rising edge.
    always @(posedge i_clk) begin
        item_taken   <= i_rst_n && item_bus.valid && item_bus.ready;
        result_taken <= i_rst_n && result_bus.valid && result_bus.ready;
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready)
                check_send();
            if (item_bus.valid && item_bus.ready)
                compute_sends('{item_bus.kind, item_bus.packet_handle,
                                item_bus.is_outbound, item_bus.now_ms});
            if (cfg_bus.valid && cfg_bus.ready)
                apply_register(cfg_bus.index, cfg_bus.data);
        end
    end

    // Item driver: a new transaction is offered only once the last one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            source_gap = 0;
        end else if (!item_bus.valid || item_taken) begin
            if (source_gap > 0) begin
                source_gap--;
                item_bus.valid <= 1'b0;
            end else if (pending_arrivals.size() > 0) begin
                next_arrival = pending_arrivals.pop_front();
                item_bus.valid         <= 1'b1;
                item_bus.kind          <= next_arrival.kind;
                item_bus.packet_handle <= next_arrival.handle;
                item_bus.is_outbound   <= next_arrival.outbound;
                item_bus.now_ms        <= next_arrival.now_ms;
                source_gap = $urandom_range(0, source_gap_max);
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Result sink: random waits per transaction, plus a long hold on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = LONG_HOLD;
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            if (result_taken)
                sink_wait = $urandom_range(0, sink_wait_max);
            if (sink_wait > 0) begin
                sink_wait--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    function automatic void add_item(input logic kind, input logic [15:0] handle,
                                     input logic outbound, input logic [31:0] now_ms);
        pending_arrivals.push_back('{kind, handle, outbound, now_ms});
    endfunction

    task automatic write_reg(input pldq_pkg::t_cfg_idx index, input logic [13:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits until every item is taken and every send has arrived, then lets
    // an item that sends nothing finish inside the block.
    task automatic wait_quiet();
        while (pending_arrivals.size() > 0 || item_bus.valid || expected_sends.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int count, input logic [31:0] start_ms,
                                  input int step_max);
        logic [31:0] clock_ms;
        int          roll;
        clock_ms = start_ms;
        for (int i = 0; i < count; i++) begin
            clock_ms += $urandom_range(0, step_max);
            roll = $urandom_range(0, 15);
            if (roll == 0)
                // An out-of-order time stamp now and then.
                add_item(pldq_pkg::KIND_PACKET, 16'($urandom()),
                         1'($urandom_range(0, 1)), 32'($urandom()));
            else
                add_item((roll < 4) ? pldq_pkg::KIND_TICK : pldq_pkg::KIND_PACKET,
                         16'($urandom()), 1'($urandom_range(0, 1)), clock_ms);
        end
    endtask

    task automatic fill_and_flush(input logic [31:0] start_ms);
        logic [31:0] clock_ms;
        clock_ms = start_ms;
        for (int i = 0; i < HELD_MAX + 2; i++) begin
            clock_ms += $urandom_range(0, 3);
            add_item(pldq_pkg::KIND_PACKET, 16'($urandom()), 1'($urandom_range(0, 1)),
                     clock_ms);
        end
        add_item(pldq_pkg::KIND_TICK, 16'($urandom()), 1'($urandom_range(0, 1)),
                 clock_ms + 32'd20000);
    endtask

    initial begin
        i_rst_n                = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.kind          = pldq_pkg::KIND_PACKET;
        item_bus.packet_handle = 16'd0;
        item_bus.is_outbound   = 1'b0;
        item_bus.now_ms        = 32'd0;
        result_bus.ready       = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = pldq_pkg::CFG_LAG_MS;
        cfg_bus.data           = 14'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: due exactly at now is held, one ms later released.
        add_item(pldq_pkg::KIND_PACKET, 16'h0000, 1'b0, 32'd1000);
        add_item(pldq_pkg::KIND_PACKET, 16'hFFFF, 1'b1, 32'd1000);
        add_item(pldq_pkg::KIND_TICK, 16'hABCD, 1'b1, 32'd1050);
        add_item(pldq_pkg::KIND_TICK, 16'h5432, 1'b0, 32'd1051);
        wait_quiet();

        // Inbound passes through, and is sent after the release it triggers.
        write_reg(pldq_pkg::CFG_LAG_INBOUND, 14'd0);
        add_item(pldq_pkg::KIND_PACKET, 16'h1234, 1'b0, 32'd2000);
        add_item(pldq_pkg::KIND_PACKET, 16'h8001, 1'b1, 32'd2000);
        add_item(pldq_pkg::KIND_PACKET, 16'h0F0F, 1'b0, 32'd2100);
        wait_quiet();

        write_reg(pldq_pkg::CFG_LAG_INBOUND, 14'h3FFF);
        write_reg(pldq_pkg::CFG_LAG_OUTBOUND, 14'd0);
        add_item(pldq_pkg::KIND_PACKET, 16'hFFFF, 1'b1, 32'd3000);
        wait_quiet();

        write_reg(pldq_pkg::CFG_LAG_MS, 14'd0);
        add_item(pldq_pkg::KIND_PACKET, 16'h00FF, 1'b0, 32'd5);
        add_item(pldq_pkg::KIND_TICK, 16'hFFFF, 1'b0, 32'd5);
        add_item(pldq_pkg::KIND_TICK, 16'h0000, 1'b1, 32'd6);
        wait_quiet();

        // A lag above the maximum saturates; a stamp near the top wraps.
        write_reg(pldq_pkg::CFG_LAG_MS, 14'h3FFF);
        add_item(pldq_pkg::KIND_PACKET, 16'h7E57, 1'b0, 32'd100);
        add_item(pldq_pkg::KIND_TICK, 16'h0001, 1'b0, 32'd15100);
        add_item(pldq_pkg::KIND_TICK, 16'h0002, 1'b1, 32'd15101);
        add_item(pldq_pkg::KIND_PACKET, 16'hC0DE, 1'b0, 32'hFFFF_FFF0);
        add_item(pldq_pkg::KIND_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        wait_quiet();

        write_reg(pldq_pkg::CFG_LAG_MS, 14'd20);
        write_reg(pldq_pkg::CFG_LAG_INBOUND, 14'd1);
        write_reg(pldq_pkg::CFG_LAG_OUTBOUND, 14'd1);
        random_traffic(15, $urandom(), 15);
        wait_quiet();

        // The sink holds off while items keep coming, so the block backs up.
        write_reg(pldq_pkg::CFG_LAG_MS, 14'd0);
        write_reg(pldq_pkg::CFG_LAG_OUTBOUND, 14'd0);
        source_gap_max = 0;
        holds_asked++;
        random_traffic(25, 32'hFFFF_FFF0, 3);
        wait_quiet();

        // No idling at all while the queue fills and flushes.
        write_reg(pldq_pkg::CFG_LAG_MS, pldq_pkg::LAG_MAX_MS);
        write_reg(pldq_pkg::CFG_LAG_OUTBOUND, 14'd1);
        sink_wait_max = 0;
        fill_and_flush($urandom());
        wait_quiet();

        write_reg(pldq_pkg::CFG_LAG_MS, 14'($urandom_range(1, 200)));
        write_reg(pldq_pkg::CFG_LAG_INBOUND, 14'd0);
        source_gap_max = 5;
        sink_wait_max  = 5;
        random_traffic(12, 32'd40000, 100);
        wait_quiet();
        random_traffic(13, 32'd42000, 100);
        wait_quiet();

        write_reg(pldq_pkg::CFG_LAG_MS, 14'($urandom_range(0, 16383)));
        write_reg(pldq_pkg::CFG_LAG_INBOUND, 14'd1);
        random_traffic(20, $urandom(), 20000);
        wait_quiet();

        while (expected_sends.size() > 0) begin
            leftover = expected_sends.pop_front();
            report_mismatch($sformatf("send never arrived: handle %h cause %0d",
                                      leftover.handle, leftover.cause));
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
